### hw/rtl/gmac_pkg.sv
// ----------------------------------------------------------------------------
// gmac_pkg
// Shared types and constants of the guard menu and alarm controller.
// ----------------------------------------------------------------------------
package gmac_pkg;

   localparam int TICK_W          = 32;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;
   localparam int REQ_DATA_W      = 40;
   localparam int RSP_DATA_W      = 72;

   localparam logic [6:0]  MAX_TIMER_MINUTES  = 7'd99;
   localparam logic [12:0] SECONDS_PER_MINUTE = 13'd60;
   localparam logic signed [14:0] TEMP_LIMIT  = 15'sd5000;
   localparam logic signed [14:0] TEMP_STEP   = 15'sd10;

   localparam logic [9:0]  RST_NEUTRAL_LOW    = 10'd450;
   localparam logic [9:0]  RST_NEUTRAL_HIGH   = 10'd550;
   localparam logic [9:0]  RST_NAV_HIGH       = 10'd600;
   localparam logic [9:0]  RST_NAV_LOW        = 10'd400;
   localparam logic [15:0] RST_CLICK_GAP      = 16'd200;
   localparam logic [15:0] RST_ADJUST_PERIOD  = 16'd120;
   localparam logic [15:0] RST_RESET_HOLD     = 16'd3000;
   localparam logic [15:0] RST_SECOND         = 16'd1000;

   localparam logic [9:0]  RST_STICK_X        = 10'd512;
   localparam logic [6:0]  RST_TIMER_MINUTES  = 7'd10;
   localparam logic signed [13:0] RST_MAX_TEMP = 14'sd750;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEUTRAL_LOW   = 3'd0,
      CSR_NEUTRAL_HIGH  = 3'd1,
      CSR_NAV_HIGH      = 3'd2,
      CSR_NAV_LOW       = 3'd3,
      CSR_CLICK_GAP     = 3'd4,
      CSR_ADJUST_PERIOD = 3'd5,
      CSR_RESET_HOLD    = 3'd6,
      CSR_SECOND        = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      SCR_INFO     = 3'd0,
      SCR_SETTEMP  = 3'd1,
      SCR_SETTIMER = 3'd2,
      SCR_ARM      = 3'd3,
      SCR_DISABLE  = 3'd4,
      SCR_CONFIRM  = 3'd5,
      SCR_ALARM    = 3'd6
   } screen_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_TEMP  = 2'd1,
      KIND_TIMER = 2'd2
   } kind_type;

   typedef enum logic {
      ACT_TICK   = 1'b0,
      ACT_SAMPLE = 1'b1
   } action_type;

   typedef struct packed {
      logic [9:0]  neutral_low;
      logic [9:0]  neutral_high;
      logic [9:0]  nav_high;
      logic [9:0]  nav_low;
      logic [15:0] click_gap_ms;
      logic [15:0] adjust_period_ms;
      logic [15:0] reset_hold_ms;
      logic [15:0] second_ms;
   } cfg_type;

   typedef struct packed {
      logic [3:0]         pad;
      logic signed [13:0] temperature;
      logic               motion;
      logic               button_level;
      logic [9:0]         stick_y;
      logic [9:0]         stick_x;
   } req_data_type;

   typedef struct packed {
      action_type   action;
      req_data_type data;
   } item_type;

   typedef struct packed {
      logic [6:0]         pad;
      logic               clear_pulse;
      logic [1:0]         confirm_kind;
      logic               choice_no;
      logic [6:0]         adjust_minutes_out;
      logic signed [13:0] adjust_temp_out;
      logic [6:0]         timer_minutes_out;
      logic signed [13:0] max_temp_out;
      logic [12:0]        seconds_left;
      logic               enabled_flag;
      logic               armed_flag;
      logic               servo_trip;
      logic [2:0]         screen;
   } rsp_data_type;

endpackage

### hw/rtl/gmac_csr.sv
// ----------------------------------------------------------------------------
// gmac_csr
// Configuration register file: thresholds and time settings.
// ----------------------------------------------------------------------------
module gmac_csr
   import gmac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_NEUTRAL_LOW:   cfg_in.neutral_low      = wr_data[9:0];
            CSR_NEUTRAL_HIGH:  cfg_in.neutral_high     = wr_data[9:0];
            CSR_NAV_HIGH:      cfg_in.nav_high         = wr_data[9:0];
            CSR_NAV_LOW:       cfg_in.nav_low          = wr_data[9:0];
            CSR_CLICK_GAP:     cfg_in.click_gap_ms     = wr_data;
            CSR_ADJUST_PERIOD: cfg_in.adjust_period_ms = wr_data;
            CSR_RESET_HOLD:    cfg_in.reset_hold_ms    = wr_data;
            CSR_SECOND:        cfg_in.second_ms        = wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neutral_low      <= RST_NEUTRAL_LOW;
         cfg_ff.neutral_high     <= RST_NEUTRAL_HIGH;
         cfg_ff.nav_high         <= RST_NAV_HIGH;
         cfg_ff.nav_low          <= RST_NAV_LOW;
         cfg_ff.click_gap_ms     <= RST_CLICK_GAP;
         cfg_ff.adjust_period_ms <= RST_ADJUST_PERIOD;
         cfg_ff.reset_hold_ms    <= RST_RESET_HOLD;
         cfg_ff.second_ms        <= RST_SECOND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/gmac_ctrl.sv
// ----------------------------------------------------------------------------
// gmac_ctrl
// Controller state and its one-step update: click qualification, page
// navigation, countdown, alarm latch and screen actions.
// ----------------------------------------------------------------------------
module gmac_ctrl
   import gmac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         step_en,
   input  item_type     item,
   output rsp_data_type result
);

   logic [TICK_W-1:0]  ms_ff, ms_in;
   logic [TICK_W-1:0]  last_click_ff, last_click_in;
   logic [TICK_W-1:0]  last_step_ff, last_step_in;
   logic [TICK_W-1:0]  last_second_ff, last_second_in;
   logic [TICK_W-1:0]  hold_start_ff, hold_start_in;
   screen_type         screen_ff, screen_in;
   logic [2:0]         page_ff, page_in;
   logic               click_pending_ff, click_pending_in;
   logic               prev_button_ff, prev_button_in;
   logic               seen_ff, seen_in;
   logic [9:0]         last_x_ff, last_x_in;
   logic               prev_motion_ff, prev_motion_in;
   logic               armed_ff, armed_in;
   logic               enabled_ff, enabled_in;
   logic [12:0]        seconds_ff, seconds_in;
   logic [6:0]         timer_ff, timer_in;
   logic [6:0]         adj_min_ff, adj_min_in;
   logic signed [13:0] max_temp_ff, max_temp_in;
   logic signed [13:0] adj_temp_ff, adj_temp_in;
   logic               choice_ff, choice_in;
   kind_type           kind_ff, kind_in;
   logic               servo_ff, servo_in;

   logic               clr;
   logic signed [3:0]  page_v;
   logic signed [14:0] temp_v;
   logic [TICK_W-1:0]  step_age;
   logic [12:0]        reload;
   screen_type         scr_sel;
   logic               up_move;
   logic               dn_move;
   logic               neutral;
   req_data_type       d;

   assign d      = item.data;
   assign reload = 13'(timer_ff) * SECONDS_PER_MINUTE;
   assign neutral = (d.stick_x > cfg.neutral_low) && (d.stick_x < cfg.neutral_high) &&
                    (d.stick_y > cfg.neutral_low) && (d.stick_y < cfg.neutral_high);
   assign up_move = (d.stick_x > cfg.nav_high) && (last_x_ff <= cfg.nav_high);
   assign dn_move = (d.stick_x < cfg.nav_low) && (last_x_ff >= cfg.nav_low);

   always_comb begin
      ms_in            = ms_ff;
      last_click_in    = last_click_ff;
      last_step_in     = last_step_ff;
      last_second_in   = last_second_ff;
      hold_start_in    = hold_start_ff;
      screen_in        = screen_ff;
      page_in          = page_ff;
      click_pending_in = click_pending_ff;
      prev_button_in   = prev_button_ff;
      seen_in          = seen_ff;
      last_x_in        = last_x_ff;
      prev_motion_in   = prev_motion_ff;
      armed_in         = armed_ff;
      enabled_in       = enabled_ff;
      seconds_in       = seconds_ff;
      timer_in         = timer_ff;
      adj_min_in       = adj_min_ff;
      max_temp_in      = max_temp_ff;
      adj_temp_in      = adj_temp_ff;
      choice_in        = choice_ff;
      kind_in          = kind_ff;
      servo_in         = servo_ff;
      clr              = 1'b0;
      page_v           = signed'({1'b0, page_ff});
      temp_v           = 15'(adj_temp_ff);
      step_age         = '0;
      scr_sel          = screen_ff;

      if (step_en && item.action == ACT_TICK) begin
         ms_in = ms_ff + 1'b1;
      end else if (step_en) begin
         // click qualification
         if (!seen_ff) begin
            seen_in = 1'b1;
         end else if (neutral && !d.button_level && prev_button_ff &&
                      ((ms_ff - last_click_ff) > TICK_W'(cfg.click_gap_ms))) begin
            click_pending_in = 1'b1;
            last_click_in    = ms_ff;
         end
         prev_button_in = d.button_level;

         // page navigation
         if (screen_ff != SCR_CONFIRM && screen_ff != SCR_ALARM) begin
            if (up_move || dn_move) begin
               click_pending_in = 1'b0;
               last_step_in     = ms_ff;
               clr              = 1'b1;
            end
            if (up_move) page_v = page_v + 4'sd1;
            if (dn_move) page_v = page_v - 4'sd1;
            if (page_v > 4'sd4) page_v = 4'sd0;
            if (page_v < 4'sd0) page_v = 4'sd4;
            page_in   = page_v[2:0];
            screen_in = screen_type'(page_v[2:0]);
         end
         if ((ms_ff - last_step_in) < TICK_W'(cfg.click_gap_ms)) click_pending_in = 1'b0;
         last_x_in = d.stick_x;

         // countdown and alarm latch
         if (armed_ff && enabled_ff) begin
            if (d.motion && !prev_motion_ff) seconds_in = reload;
            prev_motion_in = d.motion;
            if ((ms_ff - last_second_ff) > TICK_W'(cfg.second_ms)) begin
               last_second_in = ms_ff;
               if (seconds_in != '0) seconds_in = seconds_in - 1'b1;
            end
            if (seconds_in == '0 && d.temperature > max_temp_ff) begin
               armed_in  = 1'b0;
               servo_in  = 1'b1;
               screen_in = SCR_ALARM;
               clr       = 1'b1;
            end
         end

         scr_sel  = screen_in;
         step_age = ms_ff - last_step_in;
         case (scr_sel)
            SCR_SETTEMP, SCR_SETTIMER: begin
               if (step_age > TICK_W'(cfg.adjust_period_ms)) begin
                  if (scr_sel == SCR_SETTEMP) begin
                     if (d.stick_y > cfg.nav_high) temp_v = temp_v + TEMP_STEP;
                     if (d.stick_y < cfg.nav_low)  temp_v = temp_v - TEMP_STEP;
                     if (temp_v > TEMP_LIMIT)  temp_v = TEMP_LIMIT;
                     if (temp_v < -TEMP_LIMIT) temp_v = -TEMP_LIMIT;
                     adj_temp_in = temp_v[13:0];
                  end else begin
                     if (d.stick_y > cfg.nav_high && adj_min_in < MAX_TIMER_MINUTES)
                        adj_min_in = adj_min_in + 1'b1;
                     if (d.stick_y < cfg.nav_low && adj_min_in > 7'd0)
                        adj_min_in = adj_min_in - 1'b1;
                     if (adj_min_in > MAX_TIMER_MINUTES) adj_min_in = MAX_TIMER_MINUTES;
                  end
                  last_step_in = ms_ff;
               end
               if (click_pending_in) begin
                  click_pending_in = 1'b0;
                  kind_in   = (scr_sel == SCR_SETTEMP) ? KIND_TEMP : KIND_TIMER;
                  clr       = 1'b1;
                  screen_in = SCR_CONFIRM;
               end
            end
            SCR_ARM: begin
               if (click_pending_in) begin
                  click_pending_in = 1'b0;
                  enabled_in = 1'b1;
                  armed_in   = 1'b1;
                  seconds_in = reload;
                  clr        = 1'b1;
                  screen_in  = SCR_INFO;
                  page_in    = 3'(SCR_INFO);
               end
            end
            SCR_DISABLE: begin
               if (click_pending_in) begin
                  click_pending_in = 1'b0;
                  enabled_in = 1'b0;
                  armed_in   = 1'b0;
                  seconds_in = reload;
                  servo_in   = 1'b0;
                  clr        = 1'b1;
                  screen_in  = SCR_INFO;
                  page_in    = 3'(SCR_INFO);
               end
            end
            SCR_CONFIRM: begin
               if (d.stick_x < cfg.nav_low)  choice_in = 1'b0;
               if (d.stick_x > cfg.nav_high) choice_in = 1'b1;
               if (click_pending_in) begin
                  click_pending_in = 1'b0;
                  if (!choice_in) begin
                     if (kind_ff == KIND_TEMP)  max_temp_in = adj_temp_ff;
                     if (kind_ff == KIND_TIMER) timer_in    = adj_min_ff;
                  end
                  clr       = 1'b1;
                  screen_in = SCR_ARM;
                  page_in   = 3'(SCR_ARM);
               end
            end
            SCR_ALARM: begin
               if (!d.button_level) begin
                  // zero hold start means not holding
                  if (hold_start_in == '0) hold_start_in = ms_ff;
                  if ((ms_ff - hold_start_in) > TICK_W'(cfg.reset_hold_ms)) begin
                     hold_start_in = '0;
                     servo_in      = 1'b0;
                     clr           = 1'b1;
                     screen_in     = SCR_INFO;
                  end
               end else begin
                  hold_start_in = '0;
               end
            end
            default: begin
               clr = clr;
            end
         endcase
      end
   end

   always_comb begin
      result                    = '0;
      result.screen             = screen_in;
      result.servo_trip         = servo_in;
      result.armed_flag         = armed_in;
      result.enabled_flag       = enabled_in;
      result.seconds_left       = seconds_in;
      result.max_temp_out       = max_temp_in;
      result.timer_minutes_out  = timer_in;
      result.adjust_temp_out    = adj_temp_in;
      result.adjust_minutes_out = adj_min_in;
      result.choice_no          = choice_in;
      result.confirm_kind       = kind_in;
      result.clear_pulse        = clr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff            <= '0;
         last_click_ff    <= '0;
         last_step_ff     <= '0;
         last_second_ff   <= '0;
         hold_start_ff    <= '0;
         screen_ff        <= SCR_INFO;
         page_ff          <= '0;
         click_pending_ff <= 1'b0;
         prev_button_ff   <= 1'b1;
         seen_ff          <= 1'b0;
         last_x_ff        <= RST_STICK_X;
         prev_motion_ff   <= 1'b0;
         armed_ff         <= 1'b0;
         enabled_ff       <= 1'b0;
         seconds_ff       <= '0;
         timer_ff         <= RST_TIMER_MINUTES;
         adj_min_ff       <= '0;
         max_temp_ff      <= RST_MAX_TEMP;
         adj_temp_ff      <= '0;
         choice_ff        <= 1'b0;
         kind_ff          <= KIND_NONE;
         servo_ff         <= 1'b0;
      end else begin
         ms_ff            <= ms_in;
         last_click_ff    <= last_click_in;
         last_step_ff     <= last_step_in;
         last_second_ff   <= last_second_in;
         hold_start_ff    <= hold_start_in;
         screen_ff        <= screen_in;
         page_ff          <= page_in;
         click_pending_ff <= click_pending_in;
         prev_button_ff   <= prev_button_in;
         seen_ff          <= seen_in;
         last_x_ff        <= last_x_in;
         prev_motion_ff   <= prev_motion_in;
         armed_ff         <= armed_in;
         enabled_ff       <= enabled_in;
         seconds_ff       <= seconds_in;
         timer_ff         <= timer_in;
         adj_min_ff       <= adj_min_in;
         max_temp_ff      <= max_temp_in;
         adj_temp_ff      <= adj_temp_in;
         choice_ff        <= choice_in;
         kind_ff          <= kind_in;
         servo_ff         <= servo_in;
      end
   end

endmodule

### hw/rtl/guard_menu_alarm_controller_top.sv
// ----------------------------------------------------------------------------
// guard_menu_alarm_controller_top
// Menu, countdown and alarm controller with stream in/out and a CSR port.
//
// channel  direction  handshake                 payload
// req      in         req_tvalid / req_tready   req_tuser action, req_tdata sample
// rsp      out        rsp_tvalid / rsp_tready   rsp_tdata status, one beat per req beat
// csr      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One beat per cycle sustained while rsp_tready is high; each beat passes the input
// register, then the controller update into the result register.
// Synchronous active-high reset; csr_ready is always high.
// A stalled rsp holds its beat; req keeps flowing until both registers fill.
// ----------------------------------------------------------------------------
module guard_menu_alarm_controller_top
   import gmac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [9:0] stick_x, [19:10] stick_y, [20] button_level, [21] motion,
   // [35:22] temperature, [39:36] zero
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // [0] action
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [2:0] screen, [3] servo_trip, [4] armed_flag, [5] enabled_flag,
   // [18:6] seconds_left, [32:19] max_temp_out, [39:33] timer_minutes_out,
   // [53:40] adjust_temp_out, [60:54] adjust_minutes_out, [61] choice_no,
   // [63:62] confirm_kind, [64] clear_pulse, [71:65] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type      cfg;
   logic         in_valid_ff, in_valid_in;
   item_type     in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_data_ff;
   rsp_data_type next_result;
   logic         advance;
   logic         take;

   assign csr_ready  = 1'b1;
   assign advance    = !out_valid_ff || rsp_tready;
   assign take       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   gmac_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   gmac_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (take),
      .item    (in_item_ff),
      .result  (next_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) in_valid_in = req_tvalid;
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.action <= action_type'(req_tuser);
         in_item_ff.data   <= req_data_type'(req_tdata);
      end
      if (take) begin
         out_data_ff <= next_result;
      end
   end

endmodule

### tb/guard_menu_alarm_controller_top_tb.sv
// ----------------------------------------------------------------------------
// guard_menu_alarm_controller_top_tb
// Self-checking bench for the menu, countdown and alarm controller. Tick and
// sample beats go in, and each one is run through a cycle-free model of the
// menu. Every status beat that comes back is compared field by field with
// the oldest predicted status. Short directed start, then four random
// segments under different CSR settings: the receiver throttled in the
// first, the sender in the second and neither in the last two.
// ----------------------------------------------------------------------------
module guard_menu_alarm_controller_top_tb;
   import gmac_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TICK_CAP    = 30;
   localparam int PAGE_COUNT  = 5;

   class status_scoreboard;
      cfg_type         regs;
      logic [TICK_W-1:0] ms_now, click_ms, step_ms, second_mark, hold_ms;
      logic [2:0]      screen, page;
      bit              click_pend, btn_prev, primed, motion_prev;
      bit              armed, enabled, btn_now, motion_now, choice_no, servo;
      logic [9:0]      x_prev, y_now;
      logic [12:0]     secs_left;
      logic [6:0]      timer_min, edit_min;
      logic [1:0]      target;
      int              max_t, edit_t, temp_now;
      rsp_data_type    status_q[$];
      int unsigned     error_count;
      int unsigned     beat_count;

      function new();
         regs = '{RST_NEUTRAL_LOW, RST_NEUTRAL_HIGH, RST_NAV_HIGH, RST_NAV_LOW,
                  RST_CLICK_GAP, RST_ADJUST_PERIOD, RST_RESET_HOLD, RST_SECOND};
         ms_now = '0; click_ms = '0; step_ms = '0; second_mark = '0; hold_ms = '0;
         screen = SCR_INFO; page = '0;
         click_pend = 0; btn_prev = 1; primed = 0; motion_prev = 0;
         armed = 0; enabled = 0; btn_now = 1; motion_now = 0; choice_no = 0; servo = 0;
         x_prev = RST_STICK_X; y_now = RST_STICK_X;
         secs_left = '0; timer_min = RST_TIMER_MINUTES; edit_min = '0;
         target = KIND_NONE;
         max_t = RST_MAX_TEMP; edit_t = 0; temp_now = 250;
         error_count = 0; beat_count = 0;
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      function logic [TICK_W-1:0] elapsed(logic [TICK_W-1:0] mark);
         return ms_now - mark;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] v);
         case (idx)
            CSR_NEUTRAL_LOW:   regs.neutral_low      = v[9:0];
            CSR_NEUTRAL_HIGH:  regs.neutral_high     = v[9:0];
            CSR_NAV_HIGH:      regs.nav_high         = v[9:0];
            CSR_NAV_LOW:       regs.nav_low          = v[9:0];
            CSR_CLICK_GAP:     regs.click_gap_ms     = v;
            CSR_ADJUST_PERIOD: regs.adjust_period_ms = v;
            CSR_RESET_HOLD:    regs.reset_hold_ms    = v;
            CSR_SECOND:        regs.second_ms        = v;
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH beat %0d: %s", beat_count, msg);
         error_count++;
      endtask

      function void note_item(action_type act, req_data_type d);
         rsp_data_type s;
         bit           clr;
         int           pg, lim;
         logic [9:0]   x;
         clr = 0;
         lim = TEMP_LIMIT;
         if (act == ACT_TICK) begin
            ms_now = ms_now + 1'b1;
         end else begin
            x = d.stick_x;
            y_now = d.stick_y;
            btn_now = d.button_level;
            motion_now = d.motion;
            temp_now = $signed(d.temperature);

            if (!primed) begin
               primed = 1;
            end else if (x > regs.neutral_low && x < regs.neutral_high &&
                         y_now > regs.neutral_low && y_now < regs.neutral_high &&
                         !btn_now && btn_prev &&
                         elapsed(click_ms) > regs.click_gap_ms) begin
               click_pend = 1;
               click_ms = ms_now;
            end
            btn_prev = btn_now;

            if (screen != SCR_CONFIRM && screen != SCR_ALARM) begin
               pg = page;
               if (x > regs.nav_high && x_prev <= regs.nav_high) begin
                  pg++; click_pend = 0; step_ms = ms_now; clr = 1;
               end
               if (x < regs.nav_low && x_prev >= regs.nav_low) begin
                  pg--; click_pend = 0; step_ms = ms_now; clr = 1;
               end
               if (pg >= PAGE_COUNT) pg = 0;
               if (pg < 0) pg = PAGE_COUNT - 1;
               page = pg[2:0];
               screen = page;
            end
            if (elapsed(step_ms) < regs.click_gap_ms) click_pend = 0;
            x_prev = x;

            if (armed && enabled) begin
               if (motion_now && !motion_prev) secs_left = timer_min * SECONDS_PER_MINUTE;
               motion_prev = motion_now;
               if (elapsed(second_mark) > regs.second_ms) begin
                  second_mark = ms_now;
                  if (secs_left != 0) secs_left = secs_left - 13'd1;
               end
               if (secs_left == 0 && temp_now > max_t) begin
                  armed = 0; servo = 1; screen = SCR_ALARM; clr = 1;
               end
            end

            case (screen)
               SCR_SETTEMP, SCR_SETTIMER: begin
                  if (elapsed(step_ms) > regs.adjust_period_ms) begin
                     if (screen == SCR_SETTEMP) begin
                        if (y_now > regs.nav_high) edit_t += TEMP_STEP;
                        if (y_now < regs.nav_low) edit_t -= TEMP_STEP;
                        if (edit_t > lim) edit_t = lim;
                        if (edit_t < -lim) edit_t = -lim;
                     end else begin
                        if (y_now > regs.nav_high && edit_min < MAX_TIMER_MINUTES)
                           edit_min = edit_min + 7'd1;
                        if (y_now < regs.nav_low && edit_min > 0) edit_min = edit_min - 7'd1;
                        if (edit_min > MAX_TIMER_MINUTES) edit_min = MAX_TIMER_MINUTES;
                     end
                     step_ms = ms_now;
                  end
                  if (click_pend) begin
                     click_pend = 0;
                     target = (screen == SCR_SETTEMP) ? KIND_TEMP : KIND_TIMER;
                     clr = 1;
                     screen = SCR_CONFIRM;
                  end
               end
               SCR_ARM: begin
                  if (click_pend) begin
                     click_pend = 0;
                     enabled = 1; armed = 1;
                     secs_left = timer_min * SECONDS_PER_MINUTE;
                     clr = 1; screen = SCR_INFO; page = SCR_INFO;
                  end
               end
               SCR_DISABLE: begin
                  if (click_pend) begin
                     click_pend = 0;
                     enabled = 0; armed = 0;
                     secs_left = timer_min * SECONDS_PER_MINUTE;
                     servo = 0;
                     clr = 1; screen = SCR_INFO; page = SCR_INFO;
                  end
               end
               SCR_CONFIRM: begin
                  if (x < regs.nav_low) choice_no = 0;
                  if (x > regs.nav_high) choice_no = 1;
                  if (click_pend) begin
                     click_pend = 0;
                     if (!choice_no) begin
                        if (target == KIND_TEMP) max_t = edit_t;
                        if (target == KIND_TIMER) timer_min = edit_min;
                     end
                     clr = 1; screen = SCR_ARM; page = SCR_ARM;
                  end
               end
               SCR_ALARM: begin
                  if (!btn_now) begin
                     if (hold_ms == 0) hold_ms = ms_now;
                     if (elapsed(hold_ms) > regs.reset_hold_ms) begin
                        hold_ms = '0; servo = 0; clr = 1; screen = SCR_INFO;
                     end
                  end else begin
                     hold_ms = '0;
                  end
               end
               default: ;
            endcase
         end

         s = '0;
         s.screen             = screen;
         s.servo_trip         = servo;
         s.armed_flag         = armed;
         s.enabled_flag       = enabled;
         s.seconds_left       = secs_left;
         s.max_temp_out       = max_t[13:0];
         s.timer_minutes_out  = timer_min;
         s.adjust_temp_out    = edit_t[13:0];
         s.adjust_minutes_out = edit_min;
         s.choice_no          = choice_no;
         s.confirm_kind       = target;
         s.clear_pulse        = clr;
         status_q.push_back(s);
      endfunction

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      endtask

      task check_status(logic [RSP_DATA_W-1:0] raw);
         rsp_data_type got, want;
         got = raw;
         beat_count++;
         if (status_q.size() == 0) begin
            report("status beat with no prediction waiting");
            return;
         end
         want = status_q.pop_front();
         compare_field("screen", got.screen, want.screen);
         compare_field("servo_trip", got.servo_trip, want.servo_trip);
         compare_field("armed_flag", got.armed_flag, want.armed_flag);
         compare_field("enabled_flag", got.enabled_flag, want.enabled_flag);
         compare_field("seconds_left", got.seconds_left, want.seconds_left);
         compare_field("max_temp_out", got.max_temp_out, want.max_temp_out);
         compare_field("timer_minutes_out", got.timer_minutes_out, want.timer_minutes_out);
         compare_field("adjust_temp_out", got.adjust_temp_out, want.adjust_temp_out);
         compare_field("adjust_minutes_out", got.adjust_minutes_out,
                       want.adjust_minutes_out);
         compare_field("choice_no", got.choice_no, want.choice_no);
         compare_field("confirm_kind", got.confirm_kind, want.confirm_kind);
         compare_field("clear_pulse", got.clear_pulse, want.clear_pulse);
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   status_scoreboard sb = new();
   int               send_idle_pct = 7;
   int               recv_idle_pct = 82;
   int               items_sent = 0;
   int               cycle_count;
   bit               motion_level = 0;

   guard_menu_alarm_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // status beat sink with random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic cfg_type make_cfg(logic [9:0] nl, logic [9:0] nh, logic [9:0] up,
                                        logic [9:0] dn, logic [15:0] gap,
                                        logic [15:0] adj, logic [15:0] hold,
                                        logic [15:0] sec);
      cfg_type c;
      c = '{nl, nh, up, dn, gap, adj, hold, sec};
      return c;
   endfunction

   function automatic logic [9:0] pick_neutral();
      int lo, hi;
      lo = sb.regs.neutral_low + 1;
      hi = sb.regs.neutral_high - 1;
      if (lo <= hi) return 10'($urandom_range(lo, hi));
      return 10'($urandom_range(0, 1023));
   endfunction

   function automatic logic [9:0] pick_above(logic [9:0] th);
      if (th == 10'd1023) return th;
      return 10'($urandom_range(th + 1, 1023));
   endfunction

   function automatic logic [9:0] pick_below(logic [9:0] th);
      if (th == 10'd0) return th;
      return 10'($urandom_range(0, th - 1));
   endfunction

   function automatic int pick_temp();
      int t;
      case ($urandom_range(0, 3))
         0:       t = int'($urandom_range(0, 10000)) - 5000;
         3:       t = int'($urandom_range(0, 2000)) - 1000;
         default: t = sb.max_t + int'($urandom_range(0, 60)) - 30;
      endcase
      if (t > 5000) t = 5000;
      if (t < -5000) t = -5000;
      return t;
   endfunction

   function automatic int ticks_for(logic [15:0] ms);
      return (ms >= TICK_CAP) ? TICK_CAP : int'(ms) + 1;
   endfunction

   task automatic send_item(action_type act, req_data_type d);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_item(act, d);
      items_sent++;
   endtask

   task automatic send_tick();
      logic [63:0]  junk;
      req_data_type d;
      junk = {$urandom, $urandom};
      d = junk[REQ_DATA_W-1:0];
      d.pad = '0;
      send_item(ACT_TICK, d);
   endtask

   task automatic send_sample(logic [9:0] x, logic [9:0] y, bit btn, bit mot, int temp);
      req_data_type d;
      d = '0;
      d.stick_x = x;
      d.stick_y = y;
      d.button_level = btn;
      d.motion = mot;
      d.temperature = temp[13:0];
      send_item(ACT_SAMPLE, d);
   endtask

   task automatic tick_burst(int n);
      repeat (n) send_tick();
   endtask

   task automatic calm(bit btn);
      send_sample(pick_neutral(), pick_neutral(), btn, motion_level, pick_temp());
   endtask

   task automatic page_step(bit right);
      send_sample(right ? pick_above(sb.regs.nav_high) : pick_below(sb.regs.nav_low),
                  pick_neutral(), 1'b1, motion_level, pick_temp());
      calm(1'b1);
   endtask

   task automatic click();
      calm(1'b1);
      tick_burst(ticks_for(sb.regs.click_gap_ms));
      calm(1'b0);
      calm(1'b1);
   endtask

   task automatic adjust_steps(int n, bit up);
      repeat (n) begin
         tick_burst(ticks_for(sb.regs.adjust_period_ms));
         send_sample(pick_neutral(),
                     up ? pick_above(sb.regs.nav_high) : pick_below(sb.regs.nav_low),
                     1'b1, motion_level, pick_temp());
      end
   endtask

   task automatic hold_button();
      repeat ($urandom_range(1, 6)) begin
         calm(1'b0);
         tick_burst(ticks_for(sb.regs.reset_hold_ms) / 3 + 1);
      end
      if ($urandom_range(0, 1)) calm(1'b1);
   endtask

   // walk to a setting page, edit, confirm, then usually arm
   task automatic edit_and_arm();
      int goal, moves;
      if (sb.screen == SCR_CONFIRM) click();
      goal = $urandom_range(0, 1) ? SCR_SETTEMP : SCR_SETTIMER;
      moves = (goal + PAGE_COUNT - sb.page) % PAGE_COUNT;
      repeat (moves) page_step(1'b1);
      adjust_steps($urandom_range(0, 6), $urandom_range(0, 2) == 0);
      click();
      send_sample($urandom_range(0, 3) != 0 ? pick_below(sb.regs.nav_low)
                                           : pick_above(sb.regs.nav_high),
                  pick_neutral(), 1'b1, motion_level, pick_temp());
      click();
      if ($urandom_range(0, 3) != 0) click();
   endtask

   task automatic random_gesture();
      case ($urandom_range(0, 11))
         0, 1: tick_burst($urandom_range(1, 12));
         2:    page_step(1'b1);
         3:    page_step(1'b0);
         4:    click();
         5:    adjust_steps($urandom_range(1, 4), 1'($urandom_range(0, 1)));
         6: begin
            motion_level = 1'b1;
            calm(1'b1);
            tick_burst($urandom_range(1, 8));
            motion_level = 1'b0;
            calm(1'b1);
         end
         7:    hold_button();
         8, 9: begin
            if (sb.screen == SCR_ALARM) hold_button();
            else edit_and_arm();
         end
         10: begin
            repeat ($urandom_range(1, 3))
               send_sample(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 1) ? int'($urandom_range(0, 10000)) - 5000
                                                : int'($urandom_range(0, 16383)) - 8192);
         end
         default: begin
            repeat (3) begin
               tick_burst(ticks_for(sb.regs.second_ms));
               calm(1'b1);
            end
         end
      endcase
   endtask

   task automatic run_random(int n);
      int start;
      start = items_sent;
      while (items_sent - start < n) random_gesture();
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
   endtask

   task automatic load_settings(cfg_type c);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(CSR_NEUTRAL_LOW, 16'(c.neutral_low));
      write_reg(CSR_NEUTRAL_HIGH, 16'(c.neutral_high));
      write_reg(CSR_NAV_HIGH, 16'(c.nav_high));
      write_reg(CSR_NAV_LOW, 16'(c.nav_low));
      write_reg(CSR_CLICK_GAP, c.click_gap_ms);
      write_reg(CSR_ADJUST_PERIOD, c.adjust_period_ms);
      write_reg(CSR_RESET_HOLD, c.reset_hold_ms);
      write_reg(CSR_SECOND, c.second_ms);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_TICK;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_NEUTRAL_LOW;
      csr_wdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, field extremes, page wrap both ways
      send_sample(10'd512, 10'd512, 1'b0, 1'b0, 250);
      send_sample(10'd512, 10'd512, 1'b1, 1'b0, 250);
      send_tick();
      send_item(ACT_TICK, req_data_type'(40'h0F_FFFF_FFFF));
      send_sample(10'd0, 10'd0, 1'b1, 1'b1, -8192);
      send_sample(10'd1023, 10'd1023, 1'b0, 1'b0, 8191);
      send_sample(10'd512, 10'd512, 1'b1, 1'b0, -5000);
      send_sample(10'd700, 10'd512, 1'b1, 1'b0, 5000);
      send_sample(10'd512, 10'd1023, 1'b1, 1'b0, 0);
      send_sample(10'd300, 10'd512, 1'b1, 1'b0, -1);
      send_sample(10'd512, 10'd0, 1'b0, 1'b1, 1);
      send_sample(10'd451, 10'd549, 1'b1, 1'b0, 751);
      send_sample(10'd450, 10'd550, 1'b0, 1'b0, 750);
      send_sample(10'd601, 10'd399, 1'b1, 1'b1, 4999);
      send_sample(10'd400, 10'd600, 1'b1, 1'b0, -4999);
      send_sample(10'd599, 10'd401, 1'b0, 1'b0, 8190);

      load_settings(make_cfg(10'd450, 10'd550, 10'd600, 10'd400, 16'd4, 16'd2,
                             16'd12, 16'd3));
      run_random(260);

      send_idle_pct = 82;
      recv_idle_pct = 7;
      load_settings(make_cfg(10'd0, 10'd1023, 10'd0, 10'd1023, 16'd0, 16'd0,
                             16'd0, 16'd1));
      run_random(180);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings(make_cfg(10'd300, 10'd700, 10'd800, 10'd200, 16'd10, 16'd3,
                             16'd30, 16'd5));
      run_random(180);

      load_settings(make_cfg(10'd100, 10'd900, 10'd1023, 10'd0, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF));
      run_random(60);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
